### hw/rtl/rpa_pkg.sv
// Shared types and constants of the repetition penalty argmax unit.
// No dependencies; imported by every module of the block.
package rpa_pkg;

    localparam int ID_W       = 16;
    localparam int SCORE_W    = 32;
    localparam int FACT_W     = 16;
    localparam int PROD_W     = SCORE_W + FACT_W + 1;
    localparam int MAP_IDS    = 65536;
    localparam int ROW_BITS   = 32;
    localparam int ROW_SEL_W  = 5;
    localparam int Q_SHIFT    = 14;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_MARK  = 2'd1;
    localparam logic [1:0] CMD_SCORE = 2'd2;

    localparam logic REG_FACTOR = 1'b0;
    localparam logic REG_RECIP  = 1'b1;

    localparam logic [FACT_W-1:0] FACTOR_RST = 16'd18022;
    localparam logic [FACT_W-1:0] RECIP_RST  = 16'd14895;

    typedef struct packed {
        logic [FACT_W-1:0] factor;
        logic [FACT_W-1:0] recip;
    } t_penalty;

    typedef struct packed {
        logic mark_we;
        logic score_go;
        logic clear_go;
        logic sweep_we;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
    } t_dp_stat;

    typedef struct packed {
        logic            vld;
        logic            clr;
        logic            last;
        logic            cmp;
        logic [ID_W-1:0] idx;
    } t_pipe;

endpackage

### hw/rtl/rpa_regs.sv
// APB configuration registers: penalty factor and its reciprocal.
// Depends on rpa_pkg.
module rpa_regs
    import rpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_penalty              o_pen
);

    logic [FACT_W-1:0] r_factor;
    logic [FACT_W-1:0] r_recip;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RST;
            r_recip  <= RECIP_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_FACTOR: r_factor <= pwdata[FACT_W-1:0];
                REG_RECIP:  r_recip  <= pwdata[FACT_W-1:0];
                default:    r_factor <= r_factor;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FACTOR: prdata = APB_DATA_W'(r_factor);
            REG_RECIP:  prdata = APB_DATA_W'(r_recip);
            default:    prdata = '0;
        endcase
    end

    assign o_pen.factor = r_factor;
    assign o_pen.recip  = r_recip;

endmodule

### hw/rtl/rpa_ctrl.sv
// Controller: request decode and the run / map-clear state machine.
// Depends on rpa_pkg; drives rpa_dp through t_dp_cmd.
module rpa_ctrl
    import rpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_cmd,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_CLEAR = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;
    logic       w_accept;

    assign w_accept = i_start && (r_state == ST_RUN);
    assign o_busy   = (r_state == ST_CLEAR);

    always_comb begin
        o_cmd          = '0;
        o_cmd.sweep_we = (r_state == ST_CLEAR);
        case (i_cmd)
            CMD_CLEAR: o_cmd.clear_go = w_accept;
            CMD_MARK:  o_cmd.mark_we  = w_accept;
            CMD_SCORE: o_cmd.score_go = w_accept;
            default:   o_cmd.mark_we  = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN:   if (o_cmd.clear_go) n_state = ST_CLEAR;
            ST_CLEAR: if (i_stat.sweep_last) n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // reset starts a full sweep of the seen map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/rpa_dp.sv
// Datapath: seen-map memory, penalty multiply pipeline and running argmax.
// Depends on rpa_pkg; commanded by rpa_ctrl.
module rpa_dp
    import rpa_pkg::*;
#(
    parameter int VOCAB_SIZE = 65536
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  t_penalty                  i_pen,
    input  logic [ID_W-1:0]           i_mark_id,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic                      i_last,
    output t_dp_stat                  o_stat,
    output logic                      o_valid,
    output logic [ID_W-1:0]           o_token_id
);

    localparam int LIMIT  = (VOCAB_SIZE < MAP_IDS) ? VOCAB_SIZE : MAP_IDS;
    localparam int ROWS   = (LIMIT + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W  = $clog2(LIMIT + 1);

    localparam logic signed [PROD_W-1:0] Q_BIAS = PROD_W'((1 << Q_SHIFT) - 1);
    localparam logic signed [PROD_W-1:0] Q_MAX  = PROD_W'(64'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] Q_MIN  = -PROD_W'(64'sh8000_0000);
    localparam logic signed [SCORE_W-1:0] S_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] S_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    logic [ROW_BITS-1:0] r_mem [ROWS];
    logic [ROW_AW-1:0]   r_sweep;
    logic [POS_W-1:0]    r_pos;

    logic                w_mark_ok;
    logic [ROW_AW-1:0]   w_mark_row;
    logic [ROW_AW-1:0]   w_pos_row;
    logic                w_in_range;

    t_pipe                      r_s1, r_s2, r_s3;
    logic [ROW_BITS-1:0]        r_rd_row;
    logic [ROW_SEL_W-1:0]       r_s1_bit;
    logic signed [SCORE_W-1:0]  r_s1_score, r_s2_score, r_s3_val;
    logic signed [PROD_W-1:0]   r_s2_prod;
    logic                       r_s2_seen;

    logic [FACT_W-1:0]          w_fac;
    logic signed [PROD_W-1:0]   w_biased;
    logic signed [PROD_W-1:0]   w_q;
    logic signed [SCORE_W-1:0]  w_sat;

    logic signed [SCORE_W-1:0]  r_best;
    logic [ID_W-1:0]            r_best_idx;
    logic                       w_better;

    assign w_mark_ok  = {1'b0, i_mark_id} < (ID_W + 1)'(LIMIT);
    assign w_mark_row = ROW_AW'(i_mark_id >> ROW_SEL_W);
    assign w_pos_row  = ROW_AW'(r_pos >> ROW_SEL_W);
    assign w_in_range = r_pos < POS_W'(LIMIT);

    assign o_stat.sweep_last = (r_sweep == ROW_AW'(ROWS - 1));

    // seen map: sweep clear, per-bit mark, registered row read
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_we) begin
            r_mem[r_sweep] <= '0;
        end else if (i_cmd.mark_we && w_mark_ok) begin
            r_mem[w_mark_row][i_mark_id[ROW_SEL_W-1:0]] <= 1'b1;
        end
        if (i_cmd.score_go) begin
            r_rd_row <= r_mem[w_pos_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_we) begin
            r_sweep <= o_stat.sweep_last ? '0 : r_sweep + 1'b1;
        end
    end

    // score position, restarted at accept of clear or last score
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.clear_go || (i_cmd.score_go && i_last)) begin
            r_pos <= '0;
        end else if (i_cmd.score_go && w_in_range) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    // stage 1: capture request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1.vld  <= i_cmd.score_go || i_cmd.clear_go;
            r_s1.clr  <= i_cmd.clear_go;
            r_s1.last <= i_last;
            r_s1.cmp  <= w_in_range;
            r_s1.idx  <= ID_W'(r_pos);
        end
        r_s1_score <= i_score;
        r_s1_bit   <= ROW_SEL_W'(r_pos);
    end

    // stage 2: penalty product
    assign w_fac = r_s1_score[SCORE_W-1] ? i_pen.factor : i_pen.recip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= r_s1;
        end
        r_s2_prod  <= PROD_W'(r_s1_score) * PROD_W'($signed({1'b0, w_fac}));
        r_s2_seen  <= r_rd_row[r_s1_bit];
        r_s2_score <= r_s1_score;
    end

    // stage 3: round toward zero, saturate
    assign w_biased = r_s2_prod + (r_s2_prod[PROD_W-1] ? Q_BIAS : '0);
    assign w_q      = w_biased >>> Q_SHIFT;

    always_comb begin
        if (w_q > Q_MAX) begin
            w_sat = S_MAX;
        end else if (w_q < Q_MIN) begin
            w_sat = S_MIN;
        end else begin
            w_sat = w_q[SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3 <= r_s2;
        end
        r_s3_val <= r_s2_seen ? w_sat : r_s2_score;
    end

    // stage 4: running max and result
    assign w_better = r_s3.cmp && (r_s3_val > r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best     <= '0;
            r_best_idx <= '0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (r_s3.vld) begin
                if (r_s3.clr || r_s3.last) begin
                    r_best     <= '0;
                    r_best_idx <= '0;
                end else if (w_better) begin
                    r_best     <= r_s3_val;
                    r_best_idx <= r_s3.idx;
                end
                if (!r_s3.clr && r_s3.last) begin
                    o_valid <= 1'b1;
                end
            end
        end
        if (r_s3.vld && !r_s3.clr && r_s3.last) begin
            o_token_id <= w_better ? r_s3.idx : r_best_idx;
        end
    end

endmodule

### hw/rtl/repetition_penalty_argmax_unit.sv
// Repetition penalty argmax: greedy token picker over a streamed logit vector.
// Accepts one request per cycle unless busy; o_valid pulses once the last score passes
// r_s1, r_s2 and r_s3. A clear request holds busy while the seen map is swept one row per
// cycle, ceil(min(VOCAB_SIZE,65536)/32) rows (2048 by default); the same sweep runs after
// reset. Reset is synchronous, active low; results cannot be stalled by the receiver.
module repetition_penalty_argmax_unit
    import rpa_pkg::*;
#(
    parameter int VOCAB_SIZE = 65536
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_cmd,
    input  logic [ID_W-1:0]           i_mark_id,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic                      i_last,
    output logic                      o_valid,
    output logic [ID_W-1:0]           o_token_id,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready
);

    t_penalty w_pen;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rpa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_pen   (w_pen)
    );

    rpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    rpa_dp #(
        .VOCAB_SIZE (VOCAB_SIZE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_pen      (w_pen),
        .i_mark_id  (i_mark_id),
        .i_score    (i_score),
        .i_last     (i_last),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .o_token_id (o_token_id)
    );

endmodule

### hw/rtl/rpa_checker.sv
// Port-level checker for repetition_penalty_argmax_unit, attached by bind.
// Depends on rpa_pkg.
module rpa_checker
    import rpa_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_cmd,
    input logic       i_last,
    input logic       o_valid
);

    logic w_acc_last;
    assign w_acc_last = start && !busy && (i_cmd == CMD_SCORE) && i_last;

    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> busy)
        else $error("busy low right after reset");

    a_busy_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_CLEAR)) |=> busy)
        else $error("clear request did not start the map sweep");

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_last |-> ##4 o_valid)
        else $error("missing result after last score");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_acc_last, 4))
        else $error("result without a last score");

endmodule

bind repetition_penalty_argmax_unit rpa_checker u_rpa_checker (.*);

### verif/repetition_penalty_argmax_unit_tb.sv
`timescale 1ns / 1ps
// Testbench of repetition_penalty_argmax_unit: directed and random command streams
// checked against an in-bench token picker. Depends on rpa_pkg and the unit's RTL.
module repetition_penalty_argmax_unit_tb;
    import rpa_pkg::*;

    localparam int VOCAB     = 65536;
    localparam int POS_LIMIT = (VOCAB < MAP_IDS) ? VOCAB : MAP_IDS;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class token_pick_scoreboard;
        logic [FACT_W-1:0]         factor_q;
        logic [FACT_W-1:0]         recip_q;
        bit                        seen_ids[int];
        logic signed [SCORE_W-1:0] best_score;
        logic [ID_W-1:0]           best_idx;
        int                        position;
        int                        pos_limit;
        logic [ID_W-1:0]           pending_tokens[$];
        int                        failures;

        function new(int limit);
            pos_limit = limit;
            factor_q  = FACTOR_RST;
            recip_q   = RECIP_RST;
            failures  = 0;
            reset_search();
        endfunction

        function void reset_search();
            best_score = '0;
            best_idx   = '0;
            position   = 0;
        endfunction

        function void set_reg(logic sel, logic [APB_DATA_W-1:0] value);
            if (sel == REG_FACTOR) begin
                factor_q = value[FACT_W-1:0];
            end else begin
                recip_q = value[FACT_W-1:0];
            end
        endfunction

        // Q2.14 scaling, truncated toward zero, saturated to 32 bits
        function logic signed [SCORE_W-1:0] penalize(logic signed [SCORE_W-1:0] s);
            longint f;
            longint q;
            f = (s < 0) ? longint'(factor_q) : longint'(recip_q);
            q = (longint'(s) * f) / (longint'(1) << Q_SHIFT);
            if (q > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
            if (q < -longint'(64'sd2147483648)) return 32'sh80000000;
            return q[SCORE_W-1:0];
        endfunction

        function void take_request(logic [1:0] cmd, logic [ID_W-1:0] id,
                                   logic signed [SCORE_W-1:0] s, logic last);
            logic signed [SCORE_W-1:0] v;
            logic [ID_W-1:0]           p;
            case (cmd)
                CMD_CLEAR: begin
                    seen_ids.delete();
                    reset_search();
                end
                CMD_MARK: begin
                    seen_ids[int'(id)] = 1'b1;
                end
                CMD_SCORE: begin
                    if (position < pos_limit) begin
                        p = position[ID_W-1:0];
                        v = seen_ids.exists(int'(p)) ? penalize(s) : s;
                        if (v > best_score) begin
                            best_score = v;
                            best_idx   = p;
                        end
                        position++;
                    end
                    if (last) begin
                        pending_tokens = {pending_tokens, best_idx};
                        reset_search();
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_token(logic [ID_W-1:0] got);
            logic [ID_W-1:0] want;
            if (pending_tokens.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] token %0d with none expected", $realtime, got);
            end else begin
                want = pending_tokens.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= 10)
                        $display("[%0t] token mismatch: expected %0d, got %0d",
                                 $realtime, want, got);
                end
            end
        endfunction
    endclass

    logic                      i_clk     = 1'b0;
    logic                      i_rst_n   = 1'b0;
    logic                      start     = 1'b0;
    logic [1:0]                i_cmd     = CMD_CLEAR;
    logic [ID_W-1:0]           i_mark_id = '0;
    logic signed [SCORE_W-1:0] i_score   = '0;
    logic                      i_last    = 1'b0;
    logic                      psel      = 1'b0;
    logic                      penable   = 1'b0;
    logic                      pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr     = '0;
    logic [APB_DATA_W-1:0]     pwdata    = '0;
    logic                      busy;
    logic                      o_valid;
    logic [ID_W-1:0]           o_token_id;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    token_pick_scoreboard sb;
    bit steady  = 1'b0;
    int counted = 0;

    repetition_penalty_argmax_unit #(
        .VOCAB_SIZE (VOCAB)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_mark_id  (i_mark_id),
        .i_score    (i_score),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .o_token_id (o_token_id),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_token(o_token_id);
        end
    end

    initial begin
        #2_000_000;
        $display("** repetition_penalty_argmax_unit: FAILED **");
        $finish;
    end

    task automatic send_req(logic [1:0] cmd, logic [ID_W-1:0] id,
                            logic signed [SCORE_W-1:0] s, logic last);
        i_cmd     <= cmd;
        i_mark_id <= id;
        i_score   <= s;
        i_last    <= last;
        start     <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.take_request(cmd, id, s, last);
        if (cmd != CMD_UNUSED) counted++;
        if (!steady && $urandom_range(0, 99) < 20) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // drain pending tokens, cover the output latency, wait out any sweep
    task automatic settle();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (sb.pending_tokens.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic sel, logic [FACT_W-1:0] value);
        logic [APB_DATA_W-1:0] data;
        data = $urandom;
        data[FACT_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(sel, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SCORE_W-1:0] pick_score(int style);
        logic [SCORE_W-1:0] v;
        int t;
        v = $urandom;
        case (style)
            0: return v;
            1: begin
                t = $urandom_range(0, 262143);
                return t - 131072;
            end
            2: return v[SCORE_W-1] ? v : ~v;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    // one vocabulary pass: optional clear, marks, scores, with some noise mixed in
    task automatic run_sequence();
        int len;
        int style;
        logic signed [SCORE_W-1:0] val;
        logic signed [SCORE_W-1:0] prev;
        prev = '0;
        if ($urandom_range(0, 5) == 0)
            send_req(CMD_CLEAR, ID_W'($urandom), SCORE_W'($urandom),
                     1'($urandom_range(0, 1)));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        repeat ($urandom_range(0, 6)) begin
            send_req(CMD_MARK,
                     ID_W'(($urandom_range(0, 4) == 0) ? $urandom
                                                       : $urandom_range(0, len - 1)),
                     SCORE_W'($urandom), 1'($urandom_range(0, 1)));
        end
        style = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 4)
                send_req(CMD_UNUSED, ID_W'($urandom), SCORE_W'($urandom),
                         1'($urandom_range(0, 1)));
            if ($urandom_range(0, 99) < 4)
                send_req(CMD_MARK, ID_W'($urandom_range(0, len - 1)), SCORE_W'($urandom),
                         1'($urandom_range(0, 1)));
            if ($urandom_range(0, 199) == 0)
                send_req(CMD_CLEAR, ID_W'($urandom), SCORE_W'($urandom),
                         1'($urandom_range(0, 1)));
            if (i > 0 && $urandom_range(0, 4) == 0)
                val = prev;
            else
                val = pick_score(($urandom_range(0, 9) == 0) ? 0 : style);
            send_req(CMD_SCORE, ID_W'($urandom), val, i == len - 1);
            prev = val;
        end
    endtask

    initial begin
        int ph;
        int target;
        logic [FACT_W-1:0] f;
        logic [FACT_W-1:0] r;

        sb = new(POS_LIMIT);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty search, duplicate marks, unused command, saturation, ties
        send_req(CMD_SCORE, 16'h0000, 32'sd0, 1'b1);
        send_req(CMD_MARK, 16'd1, 32'sh7FFFFFFF, 1'b1);
        send_req(CMD_MARK, 16'd1, 32'sd0, 1'b0);
        send_req(CMD_MARK, 16'hFFFF, 32'sh80000000, 1'b0);
        send_req(CMD_MARK, 16'h0000, 32'sd0, 1'b0);
        send_req(CMD_UNUSED, 16'hFFFF, 32'sh7FFFFFFF, 1'b1);
        send_req(CMD_SCORE, 16'hFFFF, 32'sh7FFFFFFF, 1'b0);
        send_req(CMD_SCORE, 16'h0000, 32'sh80000000, 1'b0);
        send_req(CMD_SCORE, 16'h0000, 32'sh7FFFFFFF, 1'b0);
        send_req(CMD_SCORE, 16'h0000, 32'sh7FFFFFFF, 1'b1);
        send_req(CMD_SCORE, 16'h0000, -32'sd5, 1'b0);
        send_req(CMD_SCORE, 16'h0000, -32'sd1, 1'b1);
        send_req(CMD_SCORE, 16'h0000, -32'sd3, 1'b0);
        send_req(CMD_SCORE, 16'h0000, 32'sd1, 1'b1);
        send_req(CMD_CLEAR, 16'hFFFF, 32'sh80000000, 1'b1);
        send_req(CMD_SCORE, 16'h0000, 32'sd100, 1'b0);
        send_req(CMD_SCORE, 16'h0000, 32'sd100, 1'b1);
        settle();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin f = 16'd0;     r = 16'hFFFF;   end
                1: begin f = 16'hFFFF;  r = 16'd0;      end
                2: begin f = FACT_W'($urandom); r = FACT_W'($urandom); end
                3: begin f = 16'd16384; r = 16'd16384;  end
                default: begin f = FACTOR_RST; r = RECIP_RST; end
            endcase
            write_reg(REG_FACTOR, f);
            write_reg(REG_RECIP, r);
            steady = (ph == 2);
            target = counted + 220;
            while (counted < target) run_sequence();
            steady = 1'b0;
            settle();
        end

        settle();
        if (sb.pending_tokens.size() != 0)
            $display("%0d expected tokens never arrived", sb.pending_tokens.size());
        if (sb.failures == 0 && sb.pending_tokens.size() == 0) begin
            $display("** repetition_penalty_argmax_unit: PASSED **");
        end else begin
            $display("** repetition_penalty_argmax_unit: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_regs.sv
hw/rtl/rpa_ctrl.sv
hw/rtl/rpa_dp.sv
hw/rtl/repetition_penalty_argmax_unit.sv
hw/rtl/rpa_checker.sv
verif/repetition_penalty_argmax_unit_tb.sv
